// ===== design/rws_pkg.sv =====
package rws_pkg;

    localparam int WINDOWS_DEF = 8;
    localparam logic [31:0] DEFAULT_PERIOD = 32'd86400;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] period;
        logic [31:0] remaining;
        logic        open;
    } window_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_rsp_t;

    // end of window, saturated
    function automatic logic [31:0] win_end(input window_t w);
        logic [32:0] e;
        e = {1'b0, w.start} + {1'b0, w.length};
        win_end = e[32] ? ALL_ONES : e[31:0];
    endfunction

endpackage

// ===== design/rws_cell.sv =====
module rws_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  rws_pkg::window_t  d,
    output rws_pkg::window_t  q
);

    rws_pkg::window_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.start     <= '0;
            win_reg.length    <= '0;
            win_reg.period    <= rws_pkg::DEFAULT_PERIOD;
            win_reg.remaining <= '0;
            win_reg.open      <= 1'b0;
        end
        else if (shift)
        begin
            win_reg <= d;
        end
    end

    assign q = win_reg;

endmodule

// ===== design/rws_div.sv =====
module rws_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  rws_pkg::div_req_t req,
    output rws_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  count_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [32:0] trial;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/recurring_window_scheduler.sv =====
// channel  signals                    accepted when
// input    in_valid / in_ready        in_valid && in_ready
// output   out_valid / out_ready      out_valid && out_ready
//
// Each item visits every window once; a window that needs a catch-up division
// waits on the shared 32-step divider, and the output hand-off comes last.
// The window states circulate once round the ring of cells per item.
// Reset: all windows disabled, period 86400, no window open.
// A result holds in its register until taken; no new item is taken before.
module recurring_window_scheduler
#(
    parameter int WINDOWS = rws_pkg::WINDOWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] cur_time,
    input  logic [2:0]  window_index,
    input  logic [31:0] start_time,
    input  logic [31:0] length,
    input  logic [31:0] period,
    input  logic [31:0] repeats,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        any_open,
    output logic        opened,
    output logic        closed,
    output logic [31:0] next_start,
    output logic [31:0] active_end
);

    localparam int CW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int XW = (CW > 3) ? CW : 3;
    localparam logic [CW-1:0] LAST = CW'(WINDOWS - 1);

    typedef enum logic [1:0] {IDLE, EVAL, DIVW, FIN} state_t;

    state_t state_reg;
    logic [CW-1:0] cnt_reg;
    logic op_reg;
    logic [31:0] cur_reg, st_reg, len_reg, per_reg, rep_reg;
    logic [2:0] idx_reg;
    logic opened_reg, closed_reg, agg_reg, out_valid_reg;
    logic [31:0] ns_reg, ae_reg;
    rws_pkg::window_t work_reg;
    logic was_reg;

    rws_pkg::window_t ring_q [WINDOWS];
    rws_pkg::window_t head, ld_win, wr_win, fin_win;
    rws_pkg::div_req_t dreq;
    rws_pkg::div_rsp_t drsp;
    logic shift, need_div, hit;
    logic [31:0] ld_end, hd_end, wk_end, wr_end, diff;
    logic [32:0] tcount;
    logic [33:0] adv, snew;
    logic ev_open, ev_close;

    genvar k;
    generate
        for (k = 0; k < WINDOWS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                rws_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                 .d(wr_win), .q(ring_q[k]));
            end
            else
            begin : g_rest
                rws_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                 .d(ring_q[k-1]), .q(ring_q[k]));
            end
        end
    endgenerate

    rws_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign head = ring_q[WINDOWS-1];
    assign hit  = op_reg && (XW'(cnt_reg) == XW'(idx_reg));

    always_comb
    begin
        ld_win.start     = st_reg;
        ld_win.length    = len_reg;
        ld_win.period    = (per_reg != '0) ? per_reg : rws_pkg::DEFAULT_PERIOD;
        ld_win.remaining = (rep_reg != '0) ? rep_reg : rws_pkg::ALL_ONES;
        ld_win.open      = 1'b0;
    end

    assign ld_end = rws_pkg::win_end(ld_win);
    assign hd_end = rws_pkg::win_end(head);
    assign wk_end = rws_pkg::win_end(work_reg);
    assign diff   = cur_reg - wk_end;

    // catch-up: t = q + 1 periods, t * period = diff - rem + period
    assign tcount = {1'b0, drsp.quo} + 33'd1;
    assign adv    = {2'b0, diff} - {2'b0, drsp.rem} + {2'b0, work_reg.period};
    assign snew   = {2'b0, work_reg.start} + adv;

    always_comb
    begin
        fin_win = work_reg;
        fin_win.open = 1'b0;
        if ({1'b0, work_reg.remaining} < tcount)
        begin
            fin_win.start     = '0;
            fin_win.remaining = op_reg ? work_reg.remaining : '0;
        end
        else
        begin
            fin_win.start     = (snew[33:32] != 2'b00) ? 32'd0 : snew[31:0];
            fin_win.remaining = work_reg.remaining - tcount[31:0];
            if (!op_reg && fin_win.remaining == '0)
                fin_win.start = '0;
        end
        if (!op_reg && fin_win.remaining != '0 && fin_win.start != '0 &&
            fin_win.start <= cur_reg)
            fin_win.open = 1'b1;
    end

    always_comb
    begin
        wr_win   = head;
        need_div = 1'b0;
        shift    = 1'b0;
        ev_open  = 1'b0;
        ev_close = 1'b0;
        if (state_reg == EVAL)
        begin
            if (hit)
            begin
                wr_win = ld_win;
                need_div = (st_reg != '0) && (ld_end <= cur_reg);
            end
            else if (!op_reg && head.start != '0)
            begin
                if (hd_end <= cur_reg)
                    need_div = 1'b1;
                else if (!head.open && head.remaining != '0 && head.start <= cur_reg)
                begin
                    wr_win.open = 1'b1;
                    ev_open = 1'b1;
                end
            end
            shift = !need_div;
        end
        else if (state_reg == FIN)
        begin
            wr_win = fin_win;
            shift  = 1'b1;
            if (!op_reg)
            begin
                ev_open  = !was_reg && fin_win.open;
                ev_close = was_reg && !fin_win.open;
            end
        end
    end

    assign wr_end = rws_pkg::win_end(wr_win);

    always_comb
    begin
        dreq.start    = (state_reg == EVAL) && need_div;
        dreq.dividend = cur_reg - (hit ? ld_end : hd_end);
        dreq.divisor  = hit ? ld_win.period : head.period;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            agg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (out_valid_reg && out_ready)
                        out_valid_reg <= 1'b0;
                    if (in_valid && !out_valid_reg)
                    begin
                        state_reg <= EVAL;
                        cnt_reg   <= '0;
                    end
                end
                EVAL:
                begin
                    if (need_div)
                        state_reg <= DIVW;
                    else if (cnt_reg == LAST)
                        state_reg <= IDLE;
                end
                DIVW:
                begin
                    if (drsp.done)
                        state_reg <= FIN;
                end
                FIN:
                begin
                    state_reg <= (cnt_reg == LAST) ? IDLE : EVAL;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
            if (shift)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == LAST)
                begin
                    out_valid_reg <= 1'b1;
                    // closing clears first, opening then sets
                    if (!op_reg)
                    begin
                        if (opened_reg || ev_open)
                            agg_reg <= 1'b1;
                        else if (closed_reg || ev_close)
                            agg_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == IDLE && in_valid && !out_valid_reg)
        begin
            op_reg     <= operation;
            cur_reg    <= cur_time;
            idx_reg    <= window_index;
            st_reg     <= start_time;
            len_reg    <= length;
            per_reg    <= period;
            rep_reg    <= repeats;
            opened_reg <= 1'b0;
            closed_reg <= 1'b0;
            ns_reg     <= '0;
            ae_reg     <= '0;
        end
        if (dreq.start)
        begin
            work_reg <= hit ? ld_win : head;
            was_reg  <= head.open && !hit;
        end
        if (shift)
        begin
            opened_reg <= opened_reg | ev_open;
            closed_reg <= closed_reg | ev_close;
            if (wr_win.start != '0 && (ns_reg == '0 || wr_win.start < ns_reg))
                ns_reg <= wr_win.start;
            if (wr_win.open && (ae_reg == '0 || wr_end < ae_reg))
                ae_reg <= wr_end;
        end
    end

    assign in_ready   = (state_reg == IDLE) && !out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign any_open   = agg_reg;
    assign opened     = opened_reg;
    assign closed     = closed_reg;
    assign next_start = ns_reg;
    assign active_end = ae_reg;

endmodule

// ===== design/rws_checker.sv =====
module rws_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        any_open,
    input logic        opened,
    input logic        closed,
    input logic [31:0] next_start
);

    // one item at a time: nothing taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready straight after accept");

    a_open_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && opened) |-> any_open)
        else $error("opened event without aggregate open");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(next_start)
                                       && $stable(closed)))
        else $error("stalled result changed");

endmodule

bind recurring_window_scheduler rws_checker u_rws_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .any_open(any_open),
    .opened(opened), .closed(closed), .next_start(next_start)
);

// ===== verif/recurring_window_scheduler_tb.sv =====
`timescale 1ns / 100ps

module recurring_window_scheduler_tb;

    localparam int NWIN = 8;
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] cur;
        logic [2:0]  idx;
        logic [31:0] st;
        logic [31:0] len;
        logic [31:0] per;
        logic [31:0] rep;
    } sched_item_t;

    typedef struct packed {
        logic        any_o;
        logic        opn;
        logic        cls;
        logic [31:0] nstart;
        logic [31:0] aend;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [31:0] cur_time;
    logic [2:0]  window_index;
    logic [31:0] start_time;
    logic [31:0] length;
    logic [31:0] period;
    logic [31:0] repeats;
    logic        out_valid;
    logic        out_ready;
    logic        any_open;
    logic        opened;
    logic        closed;
    logic [31:0] next_start;
    logic [31:0] active_end;

    sched_item_t   pending_items[$];
    sched_result_t expected_results[$];
    int            mismatches;
    int            burst_left;
    int            gap_left;
    int            stall_phase;
    bit            hold_sender;

    // shadow window state
    logic [31:0] m_start[NWIN];
    logic [31:0] m_len[NWIN];
    logic [31:0] m_per[NWIN];
    logic [31:0] m_rem[NWIN];
    logic        m_open[NWIN];
    logic        m_agg;

    recurring_window_scheduler uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void queue_item(sched_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic logic [31:0] sat_end(int i);
        logic [32:0] e;
        e = {1'b0, m_start[i]} + {1'b0, m_len[i]};
        return e[32] ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    function automatic void advance_start(int i, logic [63:0] n);
        logic [63:0] s;
        s = {32'd0, m_start[i]} + {32'd0, m_per[i]} * n;
        m_start[i] = (s > 64'hFFFF_FFFF) ? 32'd0 : s[31:0];
    endfunction

    function automatic logic [63:0] skip_count(int i, logic [31:0] cur);
        logic [31:0] p;
        p = (m_per[i] != 0) ? m_per[i] : rws_pkg::DEFAULT_PERIOD;
        return {32'd0, (cur - sat_end(i)) / p} + 64'd1;
    endfunction

    function automatic sched_result_t schedule_item(sched_item_t it);
        sched_result_t r;
        logic          was;
        logic          opn;
        logic          cls;
        logic [63:0]   t;
        logic [63:0]   n;
        logic [31:0]   e;
        opn = 1'b0;
        cls = 1'b0;
        if (it.op == OP_LOAD)
        begin
            if (int'(it.idx) < NWIN)
            begin
                m_start[it.idx] = it.st;
                m_len[it.idx] = it.len;
                m_per[it.idx] = (it.per != 0) ? it.per : rws_pkg::DEFAULT_PERIOD;
                m_rem[it.idx] = (it.rep != 0) ? it.rep : rws_pkg::ALL_ONES;
                m_open[it.idx] = 1'b0;
                if (it.st != 0 && sat_end(it.idx) <= it.cur)
                begin
                    t = skip_count(it.idx, it.cur);
                    if ({32'd0, m_rem[it.idx]} < t)
                        m_start[it.idx] = 32'd0;
                    else
                    begin
                        advance_start(it.idx, t);
                        m_rem[it.idx] = m_rem[it.idx] - t[31:0];
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < NWIN; i++)
            begin
                was = m_open[i];
                if (m_start[i] != 0)
                begin
                    if (sat_end(i) <= it.cur)
                    begin
                        t = skip_count(i, it.cur);
                        n = ({32'd0, m_rem[i]} < t) ? {32'd0, m_rem[i]} : t;
                        m_open[i] = 1'b0;
                        advance_start(i, n);
                        m_rem[i] = m_rem[i] - n[31:0];
                        if (m_rem[i] == 0)
                            m_start[i] = 32'd0;
                    end
                    if (!m_open[i] && m_rem[i] != 0 && m_start[i] != 0
                        && m_start[i] <= it.cur)
                        m_open[i] = 1'b1;
                end
                if (!was && m_open[i])
                    opn = 1'b1;
                if (was && !m_open[i])
                    cls = 1'b1;
            end
            if (cls)
                m_agg = 1'b0;
            if (opn)
                m_agg = 1'b1;
        end
        r.nstart = 32'd0;
        r.aend = 32'd0;
        for (int i = 0; i < NWIN; i++)
        begin
            if (m_start[i] != 0 && (r.nstart == 0 || m_start[i] < r.nstart))
                r.nstart = m_start[i];
            if (m_open[i])
            begin
                e = sat_end(i);
                if (r.aend == 0 || e < r.aend)
                    r.aend = e;
            end
        end
        r.any_o = m_agg;
        r.opn = opn;
        r.cls = cls;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // driver: bursts with gaps, optional hold until drained
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() == 0
                     || (hold_sender && expected_results.size() != 0))
                in_valid <= 1'b0;
            else
            begin
                sched_item_t it;
                it = pending_items.pop_front();
                expected_results = {expected_results, schedule_item(it)};
                in_valid <= 1'b1;
                operation <= it.op;
                cur_time <= it.cur;
                window_index <= it.idx;
                start_time <= it.st;
                length <= it.len;
                period <= it.per;
                repeats <= it.rep;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stalls on a slow rotating pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 173;
            if (stall_phase < 60)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'd0);
            else
            begin
                sched_result_t w;
                w = expected_results.pop_front();
                if (any_open !== w.any_o)
                    report_mismatch("any_open", any_open, w.any_o);
                if (opened !== w.opn)
                    report_mismatch("opened", opened, w.opn);
                if (closed !== w.cls)
                    report_mismatch("closed", closed, w.cls);
                if (next_start !== w.nstart)
                    report_mismatch("next_start", next_start, w.nstart);
                if (active_end !== w.aend)
                    report_mismatch("active_end", active_end, w.aend);
            end
        end
    end

    function automatic sched_item_t mk(logic op, logic [31:0] cur, logic [2:0] idx,
                                        logic [31:0] st, logic [31:0] len,
                                        logic [31:0] per, logic [31:0] rep);
        sched_item_t it;
        it.op = op;
        it.cur = cur;
        it.idx = idx;
        it.st = st;
        it.len = len;
        it.per = per;
        it.rep = rep;
        return it;
    endfunction

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(1, 20);
            3: return $urandom_range(1, 200);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [31:0] clock_now;
        sched_item_t it;
        mismatches = 0;
        hold_sender = 1'b0;
        for (int i = 0; i < NWIN; i++)
        begin
            m_start[i] = 32'd0;
            m_len[i] = 32'd0;
            m_per[i] = rws_pkg::DEFAULT_PERIOD;
            m_rem[i] = 32'd0;
            m_open[i] = 1'b0;
        end
        m_agg = 1'b0;
        operation = OP_TICK;
        cur_time = 32'd0;
        window_index = 3'd0;
        start_time = 32'd0;
        length = 32'd0;
        period = 32'd0;
        repeats = 32'd0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, disabled load, catch-up, saturated end, overflow
        queue_item(mk(OP_TICK, 32'd0, 3'd0, 0, 0, 0, 0));
        queue_item(mk(OP_LOAD, 32'd100, 3'd0, 32'd0, 32'd5, 32'd10, 32'd3));
        queue_item(mk(OP_LOAD, 32'd100, 3'd1, 32'd110, 32'd5, 32'd10, 32'd3));
        queue_item(mk(OP_LOAD, 32'd100, 3'd2, 32'd10, 32'd5, 32'd10, 32'd20));
        queue_item(mk(OP_LOAD, 32'd100, 3'd3, 32'd10, 32'd5, 32'd10, 32'd2));
        queue_item(mk(OP_LOAD, 32'd100, 3'd4, 32'd10, 32'd5, 32'd10, 32'd10));
        queue_item(mk(OP_LOAD, 32'd5, 3'd5, 32'hFFFF_FFF0,
                      32'hFFFF_FFFF, 32'd0, 32'd0));
        queue_item(mk(OP_TICK, 32'd112, 3'd7, 0, 0, 0, 0));
        queue_item(mk(OP_TICK, 32'd116, 3'd0, 0, 0, 0, 0));
        queue_item(mk(OP_TICK, 32'd200, 3'd0, 0, 0, 0, 0));
        queue_item(mk(OP_LOAD, 32'd0, 3'd6, 32'hFFFF_FF00, 32'd10,
                      32'hFFFF_FFFF, 32'd0));
        queue_item(mk(OP_TICK, 32'hFFFF_FF05, 3'd0, 0, 0, 0, 0));
        queue_item(mk(OP_TICK, 32'hFFFF_FFFF, 3'd0, 0, 0, 0, 0));
        queue_item(mk(OP_LOAD, 32'hFFFF_FFFF, 3'd7, 32'd1, 32'd0,
                      32'd0, 32'hFFFF_FFFF));
        queue_item(mk(OP_TICK, 32'hFFFF_FFFF, 3'd0, 0, 0, 0, 0));
        for (int i = 0; i < NWIN; i++)
            queue_item(mk(OP_LOAD, 32'd0, i[2:0], 0, 0, 0, 0));

        // hold-off: let everything drain before the random part
        hold_sender = 1'b1;
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        @(posedge clk);
        hold_sender = 1'b0;

        // random: mostly sensible schedules with advancing time, some noise
        clock_now = $urandom_range(1000, 100000);
        for (int k = 0; k < 400; k++)
        begin
            it = mk(OP_TICK, clock_now, 3'($urandom()), $urandom(), $urandom(),
                    $urandom(), $urandom());
            if ($urandom_range(0, 9) < 3)
            begin
                it.op = OP_LOAD;
                if ($urandom_range(0, 4) != 0)
                begin
                    it.st = clock_now + $urandom_range(0, 60) - 20;
                    it.len = $urandom_range(0, 30);
                    it.per = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 80);
                    it.rep = $urandom_range(0, 6);
                end
                else
                begin
                    it.st = rnd_val();
                    it.len = rnd_val();
                    it.per = rnd_val();
                    it.rep = rnd_val();
                    it.cur = rnd_val();
                end
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    clock_now = rnd_val();
                else
                    clock_now = clock_now + $urandom_range(0, 25);
                it.cur = clock_now;
            end
            queue_item(it);
        end
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[recurring_window_scheduler] OK");
        else
            $display("[recurring_window_scheduler] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[recurring_window_scheduler] ERROR");
        $finish;
    end

endmodule
